// File: src/s2l_pkg.sv
// Package for the Gregorian to lunar date converter: the state type, the
// lunar year table for 2019 to 2050 and the month-start helper.
// Used by solar_to_lunar_date_top; it depends on nothing else.
package s2l_pkg;

  localparam int unsigned TableYears = 32;
  localparam logic [13:0] FirstYear = 14'd2019;
  localparam logic [13:0] LastYear  = 14'd2050;
  localparam logic [5:0]  DateYoeBase = 6'd19;  // FirstYear minus 2000
  localparam logic [5:0]  NyYoeBase   = 6'd18;  // new year lies in Jan/Feb
  localparam logic [14:0] DaysPerYear = 15'd365;
  localparam logic [14:0] ShortMonth  = 15'd29;
  localparam logic [14:0] LongMonth   = 15'd30;
  localparam logic [4:0]  LongLen     = 5'd30;
  localparam logic [3:0]  LastMonth   = 4'd12;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DATE,
    ST_NEWYEAR,
    ST_CHECK,
    ST_WALK,
    ST_FIN
  } state_e;

  localparam logic [3:0] NY_MONTH [TableYears] = '{
    4'd2, 4'd1, 4'd2, 4'd2, 4'd1, 4'd2, 4'd1, 4'd2,
    4'd2, 4'd1, 4'd2, 4'd2, 4'd1, 4'd2, 4'd1, 4'd2,
    4'd2, 4'd1, 4'd2, 4'd2, 4'd1, 4'd2, 4'd2, 4'd1,
    4'd2, 4'd1, 4'd2, 4'd2, 4'd1, 4'd2, 4'd2, 4'd1
  };

  localparam logic [4:0] NY_DAY [TableYears] = '{
    5'd5,  5'd25, 5'd12, 5'd1,  5'd22, 5'd10, 5'd29, 5'd17,
    5'd7,  5'd27, 5'd13, 5'd3,  5'd23, 5'd11, 5'd31, 5'd19,
    5'd8,  5'd28, 5'd15, 5'd4,  5'd24, 5'd12, 5'd1,  5'd22,
    5'd10, 5'd30, 5'd17, 5'd6,  5'd26, 5'd14, 5'd2,  5'd23
  };

  localparam logic [3:0] LEAP_AT [TableYears] = '{
    4'd0, 4'd4, 4'd0, 4'd0, 4'd2, 4'd0, 4'd6,  4'd0,
    4'd0, 4'd5, 4'd0, 4'd0, 4'd3, 4'd0, 4'd11, 4'd0,
    4'd0, 4'd6, 4'd0, 4'd0, 4'd5, 4'd0, 4'd0,  4'd2,
    4'd0, 4'd7, 4'd0, 4'd0, 4'd5, 4'd0, 4'd0,  4'd3
  };

  localparam logic [4:0] LEAP_LEN [TableYears] = '{
    5'd0, 5'd29, 5'd0, 5'd0, 5'd29, 5'd0, 5'd29, 5'd0,
    5'd0, 5'd29, 5'd0, 5'd0, 5'd29, 5'd0, 5'd29, 5'd0,
    5'd0, 5'd30, 5'd0, 5'd0, 5'd29, 5'd0, 5'd0,  5'd29,
    5'd0, 5'd29, 5'd0, 5'd0, 5'd30, 5'd0, 5'd0,  5'd30
  };

  localparam logic [11:0] LONG_MONTHS [TableYears] = '{
    12'hA95, 12'hA9D, 12'h556, 12'hAB5, 12'hAD6, 12'h6D2, 12'h765, 12'hEA5,
    12'hE4A, 12'h656, 12'hC9B, 12'h55A, 12'h56D, 12'hB69, 12'hF52, 12'h752,
    12'hB25, 12'hB0B, 12'hA4B, 12'h4AB, 12'h2BB, 12'h56D, 12'hB69, 12'hDAA,
    12'hD92, 12'hEA5, 12'hD25, 12'hA4D, 12'hA4D, 12'h2B6, 12'h5B5, 12'h2D1
  };

  // Days before the start of a month in a year that begins in March.
  function automatic logic [8:0] month_start(input logic [3:0] mi);
    logic [8:0] r;
    case (mi)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      4'd12:   r = 9'd367;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

// File: src/solar_to_lunar_date_top.sv
// Gregorian to Chinese lunar date converter, top level and only module.
// Depends on s2l_pkg for the lunar year table and the state type.
//
// Usage: a request carries a Gregorian year, month and day on the input
// channel (valid_i / stall_o) and yields exactly one result on the output
// channel (valid_o / stall_i): a validity flag, the lunar year, month, day
// and a leap-month flag. An invalid result has every other field zero.
// One request is worked on at a time; stall_o is high from the cycle after
// acceptance until the result has been moved into the output register.
// The sequencer finds the day number of the date, then that of the new
// year, and checks one against the other; a date before the new year of
// its Gregorian year retries once with the lunar year before. A year
// outside the table goes straight to the final state, and a date that
// precedes even the chosen lunar year ends there as an invalid result.
// The walk steps one month per cycle through a single shared subtractor.
// The output register parts the two sides: while a result waits under
// stall_i, the block already accepts and works on the next request and
// only holds in its final state if that one finishes first.
// Reset (rst_ni low, asynchronous) returns the sequencer to idle and drops
// valid_o; no clearing pass is needed, as the tables are constants.
module solar_to_lunar_date_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [13:0] solar_year_i,
  input  logic [3:0]  solar_month_i,
  input  logic [4:0]  solar_day_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic        valid_res_o,
  output logic [11:0] lyear_o,
  output logic [3:0]  lmonth_o,
  output logic [4:0]  lunar_day_o,
  output logic        is_leap_o
);

  s2l_pkg::state_e state_q, state_d;

  // Request and working registers.
  logic [4:0]  idx_q, idx_d;        // table index of the chosen lunar year
  logic [3:0]  mon_q, mon_d;        // Gregorian month of the request
  logic [4:0]  day_q, day_d;        // Gregorian day of the request
  logic        fallback_q, fallback_d;
  logic [14:0] days_q, days_d;      // day number of the date within the era
  logic [14:0] start_q, start_d;    // day number of the chosen new year
  logic [14:0] off_q, off_d;        // days still to walk
  logic [3:0]  month_q, month_d;    // lunar month under the walk
  logic        leap_ph_q, leap_ph_d;

  // Finished result, waiting for the output register.
  logic        rv_q, rv_d;
  logic [3:0]  rmonth_q, rmonth_d;
  logic [4:0]  rday_q, rday_d;
  logic        rleap_q, rleap_d;

  // Output register.
  logic        out_valid_q, out_valid_d;
  logic        ov_res_q, ov_res_d;
  logic [11:0] oyear_q, oyear_d;
  logic [3:0]  omonth_q, omonth_d;
  logic [4:0]  oday_q, oday_d;
  logic        oleap_q, oleap_d;

  logic in_accept;
  logic in_table;
  logic load_out;

  assign stall_o   = (state_q != s2l_pkg::ST_IDLE);
  assign in_accept = valid_i && !stall_o;
  assign in_table  = (solar_year_i >= s2l_pkg::FirstYear) &&
                     (solar_year_i <= s2l_pkg::LastYear);
  assign load_out  = (state_q == s2l_pkg::ST_FIN) && (!out_valid_q || !stall_i);

  // Day-number unit, shared between the date and the new year. It counts
  // days from the start of the era, one more than the civil count; the
  // offset only ever takes a difference, so the extra day cancels.
  logic        early_month;
  logic [5:0]  yoe;
  logic [3:0]  mi;
  logic [4:0]  dd;
  logic [14:0] doe;

  assign early_month = (mon_q <= 4'd2);

  always_comb begin
    if (state_q == s2l_pkg::ST_DATE) begin
      yoe = 6'(idx_q) + s2l_pkg::DateYoeBase - 6'(early_month);
      mi  = early_month ? (mon_q + 4'd9) : (mon_q - 4'd3);
      dd  = day_q;
    end else begin
      yoe = 6'(idx_q) + s2l_pkg::NyYoeBase;
      mi  = s2l_pkg::NY_MONTH[idx_q] + 4'd9;
      dd  = s2l_pkg::NY_DAY[idx_q];
    end
  end

  assign doe = 15'(yoe) * s2l_pkg::DaysPerYear + 15'(yoe >> 2) +
               15'(s2l_pkg::month_start(mi)) + 15'(dd);

  // The shared subtractor: date against new year, then offset against
  // each month length in turn. A borrow means the minuend was smaller.
  logic        cur_long;
  logic [14:0] month_len;
  logic [14:0] sub_a, sub_b;
  logic [15:0] diff;
  logic        borrow;

  assign cur_long = leap_ph_q ? (s2l_pkg::LEAP_LEN[idx_q] == s2l_pkg::LongLen)
                              : s2l_pkg::LONG_MONTHS[idx_q][4'(month_q - 4'd1)];
  assign month_len = cur_long ? s2l_pkg::LongMonth : s2l_pkg::ShortMonth;
  assign sub_a  = (state_q == s2l_pkg::ST_CHECK) ? days_q : off_q;
  assign sub_b  = (state_q == s2l_pkg::ST_CHECK) ? start_q : month_len;
  assign diff   = {1'b0, sub_a} - {1'b0, sub_b};
  assign borrow = diff[15];

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      s2l_pkg::ST_IDLE: begin
        if (in_accept) begin
          state_d = in_table ? s2l_pkg::ST_DATE : s2l_pkg::ST_FIN;
        end
      end
      s2l_pkg::ST_DATE: begin
        state_d = s2l_pkg::ST_NEWYEAR;
      end
      s2l_pkg::ST_NEWYEAR: begin
        state_d = s2l_pkg::ST_CHECK;
      end
      s2l_pkg::ST_CHECK: begin
        if (!borrow) begin
          state_d = s2l_pkg::ST_WALK;
        end else if (!fallback_q && (idx_q != 5'd0)) begin
          state_d = s2l_pkg::ST_NEWYEAR;
        end else begin
          state_d = s2l_pkg::ST_FIN;
        end
      end
      s2l_pkg::ST_WALK: begin
        if (borrow) begin
          state_d = s2l_pkg::ST_FIN;
        end else if (!(!leap_ph_q && (s2l_pkg::LEAP_AT[idx_q] == month_q)) &&
                     (month_q == s2l_pkg::LastMonth)) begin
          state_d = s2l_pkg::ST_FIN;
        end
      end
      s2l_pkg::ST_FIN: begin
        if (load_out) begin
          state_d = s2l_pkg::ST_IDLE;
        end
      end
      default: state_d = s2l_pkg::ST_IDLE;
    endcase
  end

  // Datapath and result updates.
  always_comb begin
    idx_d      = idx_q;
    mon_d      = mon_q;
    day_d      = day_q;
    fallback_d = fallback_q;
    days_d     = days_q;
    start_d    = start_q;
    off_d      = off_q;
    month_d    = month_q;
    leap_ph_d  = leap_ph_q;
    rv_d       = rv_q;
    rmonth_d   = rmonth_q;
    rday_d     = rday_q;
    rleap_d    = rleap_q;
    unique case (state_q)
      s2l_pkg::ST_IDLE: begin
        if (in_accept) begin
          idx_d      = 5'(solar_year_i - s2l_pkg::FirstYear);
          mon_d      = solar_month_i;
          day_d      = solar_day_i;
          fallback_d = 1'b0;
          rv_d       = 1'b0;
          rmonth_d   = 4'd0;
          rday_d     = 5'd0;
          rleap_d    = 1'b0;
        end
      end
      s2l_pkg::ST_DATE: begin
        days_d = doe;
      end
      s2l_pkg::ST_NEWYEAR: begin
        start_d = doe;
      end
      s2l_pkg::ST_CHECK: begin
        if (!borrow) begin
          off_d     = diff[14:0];
          month_d   = 4'd1;
          leap_ph_d = 1'b0;
        end else if (!fallback_q && (idx_q != 5'd0)) begin
          // Before this year's new year: retry with the lunar year before.
          idx_d      = idx_q - 5'd1;
          fallback_d = 1'b1;
        end
      end
      s2l_pkg::ST_WALK: begin
        if (borrow) begin
          rv_d     = 1'b1;
          rmonth_d = month_q;
          rday_d   = 5'(off_q + 15'd1);
          rleap_d  = leap_ph_q;
        end else begin
          off_d = diff[14:0];
          if (!leap_ph_q && (s2l_pkg::LEAP_AT[idx_q] == month_q)) begin
            leap_ph_d = 1'b1;
          end else begin
            leap_ph_d = 1'b0;
            month_d   = month_q + 4'd1;
          end
        end
      end
      s2l_pkg::ST_FIN: begin
      end
      default: begin
      end
    endcase
  end

  // Output register.
  always_comb begin
    out_valid_d = out_valid_q;
    ov_res_d    = ov_res_q;
    oyear_d     = oyear_q;
    omonth_d    = omonth_q;
    oday_d      = oday_q;
    oleap_d     = oleap_q;
    if (load_out) begin
      out_valid_d = 1'b1;
      ov_res_d    = rv_q;
      oyear_d     = rv_q ? (12'(idx_q) + s2l_pkg::FirstYear[11:0]) : 12'd0;
      omonth_d    = rmonth_q;
      oday_d      = rday_q;
      oleap_d     = rleap_q;
    end else if (!stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= s2l_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    mon_q      <= mon_d;
    day_q      <= day_d;
    fallback_q <= fallback_d;
    days_q     <= days_d;
    start_q    <= start_d;
    off_q      <= off_d;
    month_q    <= month_d;
    leap_ph_q  <= leap_ph_d;
    rv_q       <= rv_d;
    rmonth_q   <= rmonth_d;
    rday_q     <= rday_d;
    rleap_q    <= rleap_d;
    ov_res_q   <= ov_res_d;
    oyear_q    <= oyear_d;
    omonth_q   <= omonth_d;
    oday_q     <= oday_d;
    oleap_q    <= oleap_d;
  end

  assign valid_o     = out_valid_q;
  assign valid_res_o = ov_res_q;
  assign lyear_o     = oyear_q;
  assign lmonth_o    = omonth_q;
  assign lunar_day_o = oday_q;
  assign is_leap_o   = oleap_q;

  // An accepted request either starts the conversion or finishes at once.
  a_accept_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == s2l_pkg::ST_DATE) || (state_q == s2l_pkg::ST_FIN))
    else $error("accepted request did not start a conversion");

  // The walk never steps outside the twelve months.
  a_walk_month : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == s2l_pkg::ST_WALK) |-> (month_q >= 4'd1) && (month_q <= 4'd12))
    else $error("month walk left the year");

  // A valid result names a real month and day.
  a_valid_fields : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && valid_res_o) |->
      (lmonth_o >= 4'd1) && (lmonth_o <= 4'd12) &&
      (lunar_day_o >= 5'd1) && (lunar_day_o <= 5'd30))
    else $error("valid result with impossible month or day");

  // An invalid result carries zeros only.
  a_invalid_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !valid_res_o) |->
      (lyear_o == 12'd0) && (lmonth_o == 4'd0) &&
      (lunar_day_o == 5'd0) && !is_leap_o)
    else $error("invalid result with non-zero fields");

  // A result is loaded only into a free or draining output register.
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && stall_i) |=> valid_o && $stable(lunar_day_o))
    else $error("waiting result was overwritten");

endmodule
